// ===== hw/rtl/sga_pkg.sv =====
`default_nettype none
package sga_pkg;

    localparam int SITES       = 256;
    localparam int SITE_BITS   = 8;
    localparam int HEIGHT_BITS = 16;

    localparam logic [SITE_BITS-1:0]   LAST_SITE  = SITE_BITS'(SITES - 1);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = '1;

    localparam logic [2:0] REG_FEEDBACK  = 3'd0;
    localparam logic [2:0] REG_DEP_THR   = 3'd1;
    localparam logic [2:0] REG_AVA_THR   = 3'd2;
    localparam logic [2:0] REG_PRECUT    = 3'd3;
    localparam logic [2:0] REG_DEP_MODE  = 3'd4;
    localparam logic [2:0] REG_SAMPLING  = 3'd5;

    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_DEPOSIT   = 2'd1;
    localparam logic [1:0] ACT_AVALANCHE = 2'd2;
    localparam logic [1:0] ACT_SHAPE_ERR = 2'd3;

    localparam logic KIND_UPDATE = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CL, ST_CC, ST_CR,
        ST_DP_START, ST_DP_L, ST_DP_C, ST_DP_R,
        ST_AV_PRE, ST_AVL_START, ST_AVL_CHK, ST_AVR_START, ST_AVR_CHK,
        ST_DEC_RD, ST_DEC_WR
    } sga_state_t;

    typedef enum logic [1:0] { ST2_NONE, ST2_FINRD, ST2_FIN } sga_tail_t;

    // Local shape from the two neighbor differences; zero when a slope exceeds one.
    function automatic logic [2:0] classify(input logic [HEIGHT_BITS-1:0] l,
                                            input logic [HEIGHT_BITS-1:0] c,
                                            input logic [HEIGHT_BITS-1:0] r);
        logic eq1, up1, dn1, eq2, up2, dn2;
        logic [2:0] s;
        eq1 = (l == c);
        up1 = ({1'b0, l} == {1'b0, c} + 1'b1);
        dn1 = ({1'b0, c} == {1'b0, l} + 1'b1);
        eq2 = (r == c);
        up2 = ({1'b0, r} == {1'b0, c} + 1'b1);
        dn2 = ({1'b0, c} == {1'b0, r} + 1'b1);
        if (!(eq1 || up1 || dn1) || !(eq2 || up2 || dn2)) s = 3'd0;
        else if (eq1 && eq2) s = 3'd1;
        else if (dn1 && dn2) s = 3'd2;
        else if (up1 && up2) s = 3'd3;
        else if ((up1 && eq2) || (eq1 && up2)) s = 3'd4;
        else if ((dn1 && eq2) || (eq1 && dn2)) s = 3'd5;
        else s = 3'd6;
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/surface_growth_avalanche_step.sv =====
// A read's result passes a final memory read and a hand-off step; a plain update first
// reads the site and its two neighbors, a repeated deposit adds a check per site, and an
// avalanche adds a walk out to both sides and a lowering pass over the sites walked.
// One item at a time: the next item is accepted only once the last result has been issued,
// so the rate depends on the data.
// Reset: synchronous, active low; the height memory is then cleared to zero, site by site.
`default_nettype none
module surface_growth_avalanche_step
    import sga_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // site[7:0], random_value[23:8]
    input  wire logic        s_tuser,   // kind[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // height[15:0], shape_class[18:16], action[20:19],
                                        // avalanche_size[28:21], size_recorded[29], zero[31:30]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [4:0]  fb_reg;
    logic [16:0] dthr_reg, athr_reg;
    logic        pre_reg, dmode_reg, samp_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_reg    <= '0;
            dthr_reg  <= '0;
            athr_reg  <= '0;
            pre_reg   <= 1'b0;
            dmode_reg <= 1'b0;
            samp_reg  <= 1'b0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (paddr[4:2])
                REG_FEEDBACK: fb_reg    <= pwdata[4:0];
                REG_DEP_THR:  dthr_reg  <= pwdata[16:0];
                REG_AVA_THR:  athr_reg  <= pwdata[16:0];
                REG_PRECUT:   pre_reg   <= pwdata[0];
                REG_DEP_MODE: dmode_reg <= pwdata[0];
                REG_SAMPLING: samp_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_FEEDBACK: prdata = {27'd0, fb_reg};
            REG_DEP_THR:  prdata = {15'd0, dthr_reg};
            REG_AVA_THR:  prdata = {15'd0, athr_reg};
            REG_PRECUT:   prdata = {31'd0, pre_reg};
            REG_DEP_MODE: prdata = {31'd0, dmode_reg};
            REG_SAMPLING: prdata = {31'd0, samp_reg};
            default:      prdata = '0;
        endcase
    end

    // Height memory: one write and one registered read per cycle.
    logic [HEIGHT_BITS-1:0] mem [SITES];
    logic                   mem_we;
    logic [SITE_BITS-1:0]   mem_waddr, mem_raddr;
    logic [HEIGHT_BITS-1:0] mem_wdata, rdata;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rdata <= mem[mem_raddr];
    end

    sga_state_t state_reg, state_next;
    sga_tail_t  tail_reg, tail_next;
    logic [SITE_BITS-1:0]   site_reg, site_next, cnt_reg, cnt_next;
    logic [SITE_BITS-1:0]   p_reg, p_next, left_reg, left_next, right_reg, right_next;
    logic [SITE_BITS-1:0]   j_reg, j_next;
    logic [1:0]             pidx_reg, pidx_next, act_reg, act_next;
    logic                   chg_reg, chg_next;
    logic [15:0]            rnd_reg, rnd_next;
    logic [HEIGHT_BITS-1:0] hl_reg, hl_next, hc_reg, hc_next, hq_reg, hq_next;
    logic [2:0]             shape_reg, shape_next, sh;
    logic [SITE_BITS-1:0]   size_reg, size_next;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_data_reg, out_data_next;
    logic                   in_set;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            tail_reg      <= ST2_NONE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        site_reg     <= site_next;
        p_reg        <= p_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        j_reg        <= j_next;
        pidx_reg     <= pidx_next;
        act_reg      <= act_next;
        chg_reg      <= chg_next;
        rnd_reg      <= rnd_next;
        hl_reg       <= hl_next;
        hc_reg       <= hc_next;
        hq_reg       <= hq_next;
        shape_reg    <= shape_next;
        size_reg     <= size_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        tail_next      = tail_reg;
        site_next      = site_reg;
        cnt_next       = cnt_reg;
        p_next         = p_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        j_next         = j_reg;
        pidx_next      = pidx_reg;
        act_next       = act_reg;
        chg_next       = chg_reg;
        rnd_next       = rnd_reg;
        hl_next        = hl_reg;
        hc_next        = hc_reg;
        hq_next        = hq_reg;
        shape_next     = shape_reg;
        size_next      = size_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = site_reg;
        mem_wdata      = '0;
        mem_raddr      = site_reg;
        s_tready       = 1'b0;
        sh             = '0;
        in_set         = 1'b0;

        // The result tail runs only from the idle state: final read, then hand-off.
        if (state_reg == ST_IDLE && tail_reg == ST2_FINRD) begin
            tail_next = ST2_FIN;
        end else if (state_reg == ST_IDLE && tail_reg == ST2_FIN) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_next = 1'b1;
                out_data_next  = {2'b00, (size_reg != '0) && samp_reg, size_reg,
                                  act_reg, shape_reg, rdata};
                tail_next      = ST2_NONE;
            end
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_SITE) state_next = ST_IDLE;
                end
                ST_IDLE: begin
                    s_tready = 1'b1;
                    if (s_tvalid) begin
                        site_next  = s_tdata[7:0];
                        rnd_next   = s_tdata[23:8];
                        shape_next = '0;
                        act_next   = ACT_NONE;
                        size_next  = '0;
                        if (s_tuser == KIND_UPDATE && s_tdata[7:0] != '0
                                && s_tdata[7:0] != LAST_SITE) begin
                            mem_raddr  = s_tdata[7:0] - 1'b1;
                            state_next = ST_CL;
                        end else begin
                            tail_next = ST2_FINRD;
                        end
                    end
                end
                ST_CL: begin
                    hl_next    = rdata;
                    state_next = ST_CC;
                end
                ST_CC: begin
                    hc_next    = rdata;
                    mem_raddr  = site_reg + 1'b1;
                    state_next = ST_CR;
                end
                ST_CR: begin
                    sh         = classify(hl_reg, hc_reg, rdata);
                    shape_next = sh;
                    in_set     = (sh == 3'd1) || (sh >= 3'd2 && fb_reg[sh - 3'd2]);
                    state_next = ST_IDLE;
                    tail_next  = ST2_FINRD;
                    if (sh == 3'd0) begin
                        act_next = ACT_SHAPE_ERR;
                    end else if (in_set) begin
                        if ({1'b0, rnd_reg} < dthr_reg) begin
                            act_next = ACT_DEPOSIT;
                            if (dmode_reg) begin
                                p_next     = site_reg - 1'b1;
                                pidx_next  = '0;
                                chg_next   = 1'b0;
                                state_next = ST_DP_START;
                                tail_next  = ST2_NONE;
                            end else if ((sh == 3'd1 || sh == 3'd3 || sh == 3'd4)
                                         && hc_reg != HEIGHT_MAX) begin
                                mem_we    = 1'b1;
                                mem_wdata = hc_reg + 1'b1;
                            end
                        end
                    end else if ({1'b0, rnd_reg} < athr_reg) begin
                        act_next   = ACT_AVALANCHE;
                        state_next = ST_AV_PRE;
                        tail_next  = ST2_NONE;
                    end
                end
                ST_DP_START: begin
                    if (p_reg == '0 || p_reg == LAST_SITE) begin
                        // End sites never take a deposit; skip to the next site, or restart or finish the pass.
                        if (pidx_reg != 2'd2) begin
                            p_next    = p_reg + 1'b1;
                            pidx_next = pidx_reg + 1'b1;
                        end else if (chg_reg) begin
                            p_next    = site_reg - 1'b1;
                            pidx_next = '0;
                            chg_next  = 1'b0;
                        end else begin
                            state_next = ST_IDLE;
                            tail_next  = ST2_FINRD;
                        end
                    end else begin
                        mem_raddr  = p_reg - 1'b1;
                        state_next = ST_DP_L;
                    end
                end
                ST_DP_L: begin
                    hl_next    = rdata;
                    mem_raddr  = p_reg;
                    state_next = ST_DP_C;
                end
                ST_DP_C: begin
                    mem_raddr  = p_reg + 1'b1;
                    state_next = ST_DP_R;
                end
                ST_DP_R: begin
                    hl_next = hl_reg;
                    state_next = ST_DP_START;
                    sh = classify(hl_reg, hq_reg, rdata);
                    if ((sh == 3'd1 || sh == 3'd3 || sh == 3'd4) && hq_reg != HEIGHT_MAX) begin
                        mem_we    = 1'b1;
                        mem_waddr = p_reg;
                        mem_wdata = hq_reg + 1'b1;
                        chg_next  = 1'b1;
                    end
                    if (pidx_reg != 2'd2) begin
                        p_next    = p_reg + 1'b1;
                        pidx_next = pidx_reg + 1'b1;
                    end else if (chg_next) begin
                        p_next    = site_reg - 1'b1;
                        pidx_next = '0;
                        chg_next  = 1'b0;
                    end else begin
                        state_next = ST_IDLE;
                        tail_next  = ST2_FINRD;
                    end
                end
                ST_AV_PRE: begin
                    left_next  = site_reg;
                    right_next = site_reg;
                    if (pre_reg && hc_reg != '0) begin
                        mem_we    = 1'b1;
                        mem_wdata = hc_reg - 1'b1;
                        hq_next   = hc_reg - 1'b1;
                    end else begin
                        hq_next = hc_reg;
                    end
                    state_next = ST_AVL_START;
                end
                ST_AVL_START: begin
                    if (left_reg == '0) begin
                        state_next = ST_AVR_START;
                    end else begin
                        mem_raddr  = left_reg - 1'b1;
                        state_next = ST_AVL_CHK;
                    end
                end
                ST_AVL_CHK: begin
                    if (rdata > hq_reg) begin
                        left_next  = left_reg - 1'b1;
                        state_next = ST_AVL_START;
                    end else begin
                        state_next = ST_AVR_START;
                    end
                end
                ST_AVR_START: begin
                    if (right_reg == LAST_SITE) begin
                        j_next     = left_reg;
                        state_next = ST_DEC_RD;
                    end else begin
                        mem_raddr  = right_reg + 1'b1;
                        state_next = ST_AVR_CHK;
                    end
                end
                ST_AVR_CHK: begin
                    if (rdata > hq_reg) begin
                        right_next = right_reg + 1'b1;
                        state_next = ST_AVR_START;
                    end else begin
                        j_next     = left_reg;
                        state_next = ST_DEC_RD;
                    end
                end
                ST_DEC_RD: begin
                    size_next = right_reg - left_reg;
                    if (j_reg == site_reg) begin
                        if (j_reg == right_reg) begin
                            state_next = ST_IDLE;
                            tail_next  = ST2_FINRD;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end else begin
                        mem_raddr  = j_reg;
                        state_next = ST_DEC_WR;
                    end
                end
                ST_DEC_WR: begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg;
                    mem_wdata = rdata - 1'b1;
                    if (j_reg == right_reg) begin
                        state_next = ST_IDLE;
                        tail_next  = ST2_FINRD;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_DEC_RD;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end

        // The deposit pass keeps the center height of the site under test in hq.
        if (state_reg == ST_DP_C) hq_next = rdata;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sga_checker.sv =====
`default_nettype none
module sga_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        pready
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:16] != 3'd7)
        else $error("shape class out of range");

    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20:19] != 2'd2 |-> m_tdata[29:21] == 9'd0)
        else $error("avalanche size without an avalanche");

    a_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[29] |-> m_tdata[28:21] != 8'd0)
        else $error("recorded flag with zero size");

    a_ready: assert property (@(posedge aclk) pready)
        else $error("configuration port not ready");

endmodule

bind surface_growth_avalanche_step sga_checker u_sga_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .pready(pready)
);
`default_nettype wire

// ===== verif/sga_scoreboard.sv =====
`default_nettype none
module sga_scoreboard
    import sga_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // site[7:0], random_value[23:8]
    input  wire logic        s_tuser,   // kind[0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // height[15:0], shape_class[18:16], action[20:19],
                                        // avalanche_size[28:21], size_recorded[29]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               mismatches,
    output int               outstanding,
    output int               deposits_seen,
    output int               avalanches_seen
);

    typedef struct packed {
        logic [15:0] height;
        logic [2:0]  shape;
        logic [1:0]  action;
        logic [7:0]  size;
        logic        recorded;
    } surface_result_t;

    logic [HEIGHT_BITS-1:0] profile [SITES];
    logic [4:0]  fb_mask;
    logic [16:0] dep_thr;
    logic [16:0] ava_thr;
    logic        precut;
    logic        dep_repeat;
    logic        sampling;

    surface_result_t pending_results[$];

    function automatic logic [2:0] local_shape(input int q);
        int d1, d2;
        d1 = int'(profile[q-1]) - int'(profile[q]);
        d2 = int'(profile[q+1]) - int'(profile[q]);
        if (d1 < -1 || d1 > 1 || d2 < -1 || d2 > 1) return 3'd0;
        if (d1 == 0 && d2 == 0) return 3'd1;
        if (d1 == -1 && d2 == -1) return 3'd2;
        if (d1 == 1 && d2 == 1) return 3'd3;
        if (d1 + d2 == 1) return 3'd4;
        if (d1 + d2 == -1) return 3'd5;
        return 3'd6;
    endfunction

    // A site grows only if it is interior, locally flat, in a dip or beside one higher neighbor, and not saturated.
    function automatic bit grow_site(input int q);
        logic [2:0] s;
        if (q <= 0 || q >= SITES - 1) return 0;
        s = local_shape(q);
        if (!(s == 3'd1 || s == 3'd3 || s == 3'd4)) return 0;
        if (profile[q] == HEIGHT_MAX) return 0;
        profile[q] = profile[q] + 1'b1;
        return 1;
    endfunction

    function automatic int topple(input int q);
        int lo, hi, j;
        lo = q;
        hi = q;
        if (precut && profile[q] != '0) profile[q] = profile[q] - 1'b1;
        while (lo > 0 && profile[lo-1] > profile[q]) lo--;
        while (hi < SITES - 1 && profile[hi+1] > profile[q]) hi++;
        for (j = lo; j <= hi; j++)
            if (j != q) profile[j] = profile[j] - 1'b1;
        return hi - lo;
    endfunction

    function automatic surface_result_t advance_surface(input logic kind,
                                                        input int site,
                                                        input logic [15:0] rnd);
        surface_result_t r;
        bit again, member;
        int sz;
        r = '0;
        if (kind == KIND_UPDATE && site >= 1 && site < SITES - 1) begin
            r.shape = local_shape(site);
            if (r.shape == 3'd0) begin
                r.action = ACT_SHAPE_ERR;
            end else begin
                member = (r.shape == 3'd1) || fb_mask[r.shape - 3'd2];
                if (member) begin
                    if (17'(rnd) < dep_thr) begin
                        r.action = ACT_DEPOSIT;
                        if (!dep_repeat) begin
                            void'(grow_site(site));
                        end else begin
                            again = 1;
                            while (again) begin
                                again = 0;
                                if (grow_site(site - 1)) again = 1;
                                if (grow_site(site)) again = 1;
                                if (grow_site(site + 1)) again = 1;
                            end
                        end
                    end
                end else if (17'(rnd) < ava_thr) begin
                    sz = topple(site);
                    r.action = ACT_AVALANCHE;
                    r.size = 8'(sz);
                    r.recorded = (sz > 0) && sampling;
                end
            end
        end
        r.height = (site < SITES) ? profile[site] : '0;
        return r;
    endfunction

    assign outstanding = pending_results.size();

    always @(posedge aclk) begin
        surface_result_t want, got;
        if (!aresetn) begin
            foreach (profile[i]) profile[i] = '0;
            fb_mask <= '0;
            dep_thr <= '0;
            ava_thr <= '0;
            precut <= 1'b0;
            dep_repeat <= 1'b0;
            sampling <= 1'b0;
            mismatches <= 0;
            deposits_seen <= 0;
            avalanches_seen <= 0;
            pending_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_FEEDBACK: fb_mask    <= pwdata[4:0];
                    REG_DEP_THR:  dep_thr    <= pwdata[16:0];
                    REG_AVA_THR:  ava_thr    <= pwdata[16:0];
                    REG_PRECUT:   precut     <= pwdata[0];
                    REG_DEP_MODE: dep_repeat <= pwdata[0];
                    REG_SAMPLING: sampling   <= pwdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = surface_result_t'({m_tdata[15:0], m_tdata[18:16], m_tdata[20:19],
                                         m_tdata[28:21], m_tdata[29]});
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $time, m_tdata);
                    mismatches <= mismatches + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (got.action == ACT_DEPOSIT) deposits_seen <= deposits_seen + 1;
                    if (got.action == ACT_AVALANCHE) avalanches_seen <= avalanches_seen + 1;
                    if (got.height != want.height || got.shape != want.shape ||
                        got.action != want.action || got.size != want.size ||
                        got.recorded != want.recorded) begin
                        $display("%0t: result mismatch, expected h=%0d s=%0d a=%0d n=%0d r=%0d",
                                 $time, want.height, want.shape, want.action, want.size,
                                 want.recorded);
                        $display("%0t:                   actual h=%0d s=%0d a=%0d n=%0d r=%0d",
                                 $time, got.height, got.shape, got.action, got.size,
                                 got.recorded);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.insert(pending_results.size(),
                                       advance_surface(s_tuser, int'(s_tdata[7:0]),
                                                       s_tdata[23:8]));
        end
    end

endmodule
`default_nettype wire

// ===== verif/surface_growth_avalanche_step_test.sv =====
`default_nettype none
module surface_growth_avalanche_step_test;
    import sga_pkg::*;

    localparam int STALL_LIMIT = 40000;
    localparam int PHASE_ITEMS = 240;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches, outstanding, deposits_seen, avalanches_seen;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    surface_growth_avalanche_step dut (.*);

    sga_scoreboard checker_i (.*);

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic setup_surface(input logic [4:0] fb, input logic [16:0] dthr,
                                 input logic [16:0] athr, input logic pre,
                                 input logic rep, input logic samp);
        drain();
        apb_write(REG_FEEDBACK, 32'(fb));
        apb_write(REG_DEP_THR, 32'(dthr));
        apb_write(REG_AVA_THR, 32'(athr));
        apb_write(REG_PRECUT, 32'(pre));
        apb_write(REG_DEP_MODE, 32'(rep));
        apb_write(REG_SAMPLING, 32'(samp));
    endtask

    task automatic send_item(input logic kind, input logic [7:0] site,
                             input logic [15:0] rnd);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {rnd, site};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        items_sent++;
    endtask

    task automatic random_phase();
        int pick, base;
        base = $urandom_range(2, 240);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_item(~KIND_UPDATE, 8'($urandom_range(255)), 16'($urandom));
            else if (pick < 14)
                send_item(KIND_UPDATE, ($urandom_range(1)) ? 8'd0 : 8'd255, 16'($urandom));
            else if (pick < 60)
                // A narrow window lets the profile pile up and topple over wide ranges.
                send_item(KIND_UPDATE, 8'(base + $urandom_range(12)), 16'($urandom));
            else
                send_item(KIND_UPDATE, 8'($urandom_range(1, 254)), 16'($urandom));
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers at reset values: updates do nothing, ends and reads report zero.
        send_item(~KIND_UPDATE, 8'd0, 16'hFFFF);
        send_item(~KIND_UPDATE, 8'd255, 16'h0000);
        send_item(KIND_UPDATE, 8'd0, 16'h0000);
        send_item(KIND_UPDATE, 8'd255, 16'h0000);
        send_item(KIND_UPDATE, 8'd128, 16'h0000);
        s_tvalid <= 1'b0;
        @(posedge aclk);

        setup_surface(5'd0, 17'd65536, 17'd65536, 1'b0, 1'b0, 1'b1);
        send_item(KIND_UPDATE, 8'd10, 16'h0000);
        send_item(KIND_UPDATE, 8'd9, 16'hFFFF);
        send_item(KIND_UPDATE, 8'd11, 16'h8000);
        send_item(KIND_UPDATE, 8'd10, 16'hFFFF);
        // The left site is now flat again and takes a deposit.
        send_item(KIND_UPDATE, 8'd9, 16'h0001);
        send_item(~KIND_UPDATE, 8'd10, 16'h0000);
        send_item(KIND_UPDATE, 8'd1, 16'hFFFF);
        send_item(KIND_UPDATE, 8'd254, 16'hFFFF);
        send_item(~KIND_UPDATE, 8'd254, 16'h0000);
        send_item(KIND_UPDATE, 8'd10, 16'hFFFF);
        s_tvalid <= 1'b0;
        @(posedge aclk);

        setup_surface(5'd31, 17'd65536, 17'd65536, 1'b1, 1'b1, 1'b0);
        send_item(KIND_UPDATE, 8'd50, 16'hFFFF);
        send_item(KIND_UPDATE, 8'd50, 16'h0000);
        send_item(KIND_UPDATE, 8'd51, 16'h1234);
        send_item(~KIND_UPDATE, 8'd49, 16'h0000);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        setup_surface(5'd0, 17'd0, 17'd65536, 1'b1, 1'b0, 1'b1);
        send_item(KIND_UPDATE, 8'd50, 16'hFFFF);
        send_item(KIND_UPDATE, 8'd10, 16'h0000);
        s_tvalid <= 1'b0;
        @(posedge aclk);

        setup_surface(5'd0, 17'd40000, 17'd30000, 1'b0, 1'b0, 1'b1);
        src_idle_pct = 0;  snk_stall_pct = 0;
        random_phase();
        setup_surface(5'd31, 17'd65536, 17'd0, 1'b1, 1'b1, 1'b0);
        src_idle_pct = 62; snk_stall_pct = 0;
        random_phase();
        setup_surface(5'b10101, 17'd0, 17'd65536, 1'b1, 1'b0, 1'b1);
        src_idle_pct = 0;  snk_stall_pct = 62;
        random_phase();
        setup_surface(5'b01010, 17'd50000, 17'd65536, 1'b0, 1'b1, 1'b1);
        src_idle_pct = 32; snk_stall_pct = 32;
        random_phase();
        setup_surface(5'd0, 17'd65535, 17'd65535, 1'b1, 1'b0, 1'b1);
        src_idle_pct = 0;  snk_stall_pct = 0;
        random_phase();
        setup_surface(5'b00110, 17'd30000, 17'd50000, 1'b0, 1'b1, 1'b0);
        src_idle_pct = 32; snk_stall_pct = 32;
        random_phase();

        while (outstanding != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Ran %0d items through directed cases and six random register settings",
                 items_sent);
        $display("under four idling mixes; the block reported %0d deposits and %0d avalanches.",
                 deposits_seen, avalanches_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
